/* hdl/rtd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_pkg: shared types and constants of the reaction tap detector
// Item layouts, operation/event/mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rtd_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int COUNTER_BITS = 16;
  localparam int LEVEL_BITS   = 12;
  localparam int TIME_BITS    = 16;
  localparam int TOTAL_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [TIME_BITS-1:0] RETURN_DELAY = TIME_BITS'(300);

  // operation codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_START      = 3'd1;
  localparam logic [2:0] OP_STOP       = 3'd2;
  localparam logic [2:0] OP_ACTIVATE   = 3'd3;
  localparam logic [2:0] OP_DEACTIVATE = 3'd4;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_HIT   = 2'd1;
  localparam logic [1:0] EV_MISS  = 2'd2;
  localparam logic [1:0] EV_DEBUG = 2'd3;

  // reported mode codes
  localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_CODE_WAIT  = 3'd1;
  localparam logic [2:0] MODE_CODE_ARMED = 3'd2;
  localparam logic [2:0] MODE_CODE_HIT   = 3'd3;
  localparam logic [2:0] MODE_CODE_MISS  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_SPIKE       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRACE           = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBUG_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBUG_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBUG_SPIKE     = 3'd7;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_WAIT  = 5'b00010,
    MODE_ARMED = 5'b00100,
    MODE_HIT   = 5'b01000,
    MODE_MISS  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [2:0]             operation;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [TIME_BITS-1:0]  time_ms;
    logic [2:0]            mode;
    logic [TOTAL_BITS-1:0] hit_count;
    logic [TOTAL_BITS-1:0] miss_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  default_timeout_ms;
    logic [TIME_BITS-1:0]  debounce_ticks;
    logic [LEVEL_BITS-1:0] tap_threshold;
    logic [LEVEL_BITS-1:0] tap_spike;
    logic [TIME_BITS-1:0]  grace_ms;
    logic                  debug_enable;
    logic [LEVEL_BITS-1:0] debug_threshold;
    logic [LEVEL_BITS-1:0] debug_spike;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    default_timeout_ms: TIME_BITS'(3000),
    debounce_ticks:     TIME_BITS'(100),
    tap_threshold:      LEVEL_BITS'(150),
    tap_spike:          LEVEL_BITS'(50),
    grace_ms:           TIME_BITS'(300),
    debug_enable:       1'b0,
    debug_threshold:    LEVEL_BITS'(100),
    debug_spike:        LEVEL_BITS'(30)
  };

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] c;
    c = MODE_CODE_IDLE;
    case (m)
      MODE_IDLE:  c = MODE_CODE_IDLE;
      MODE_WAIT:  c = MODE_CODE_WAIT;
      MODE_ARMED: c = MODE_CODE_ARMED;
      MODE_HIT:   c = MODE_CODE_HIT;
      MODE_MISS:  c = MODE_CODE_MISS;
      default:    c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/rtd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_cfg_regs: configuration register file
// Write-only registers, loaded by index, with their documented reset values.
// ----------------------------------------------------------------------------
module rtd_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rtd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [rtd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output rtd_pkg::cfg_t                           cfg_o
);
  import rtd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEFAULT_TIMEOUT: cfg_d.default_timeout_ms = cfg_wdata_i[TIME_BITS-1:0];
        REG_DEBOUNCE:        cfg_d.debounce_ticks     = cfg_wdata_i[TIME_BITS-1:0];
        REG_TAP_THRESHOLD:   cfg_d.tap_threshold      = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_TAP_SPIKE:       cfg_d.tap_spike          = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_GRACE:           cfg_d.grace_ms           = cfg_wdata_i[TIME_BITS-1:0];
        REG_DEBUG_ENABLE:    cfg_d.debug_enable       = cfg_wdata_i[0];
        REG_DEBUG_THRESHOLD: cfg_d.debug_threshold    = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_DEBUG_SPIKE:     cfg_d.debug_spike        = cfg_wdata_i[LEVEL_BITS-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* hdl/reaction_tap_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item lands in the input register, and its result is
//   registered in the result register, which drives the output.
// Throughput: one item per cycle if not stalled; the tick update is a single
//   pass of counter increments and level compares, input to result register.
// Reset: asynchronous, active low; mode idle, counters and totals cleared,
//   debounce counters saturated, registers at their documented defaults.
// ----------------------------------------------------------------------------
// reaction_tap_detector: reaction-time trainer for a piezo pad
// Tracks arming, grace, debounce, hits, misses and debug taps per 1 ms tick.
// ----------------------------------------------------------------------------
module reaction_tap_detector #(
  parameter int CounterBits = rtd_pkg::COUNTER_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rtd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [rtd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rtd_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rtd_pkg::out_item_t                      out_item_o
);
  import rtd_pkg::*;

  // comparison width covering both counters and 16-bit register values
  localparam int CmpBits = (CounterBits > TIME_BITS) ? CounterBits : TIME_BITS;
  localparam int SumBits = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 1;

  cfg_t cfg;

  rtd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // state
  mode_e                   mode_q, mode_d;
  logic [CounterBits-1:0]  arm_cnt_q, arm_cnt_d;
  logic [CounterBits-1:0]  hit_cnt_q, hit_cnt_d;
  logic [CounterBits-1:0]  chg_cnt_q, chg_cnt_d;
  logic [CounterBits-1:0]  dbg_cnt_q, dbg_cnt_d;
  logic [SAMPLE_BITS-1:0]  baseline_q, baseline_d;
  logic [SAMPLE_BITS-1:0]  prev_q, prev_d;
  logic [TIME_BITS-1:0]    timeout_q, timeout_d;
  logic [TOTAL_BITS-1:0]   hits_q, hits_d;
  logic [TOTAL_BITS-1:0]   misses_q, misses_d;

  // tick datapath
  logic [CounterBits-1:0]  arm_inc, hit_inc, chg_inc, dbg_inc;
  logic [CmpBits-1:0]      arm_w, hit_w, dbg_w;
  logic [SumBits-1:0]      smp_w, arm_lim, dbg_lim;
  logic                    armed_tap, debug_tap, in_grace;
  logic [1:0]              ev;
  logic [CmpBits-1:0]      tm_w;

  assign arm_inc = (arm_cnt_q == '1) ? arm_cnt_q : arm_cnt_q + 1'b1;
  assign hit_inc = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign chg_inc = (chg_cnt_q == '1) ? chg_cnt_q : chg_cnt_q + 1'b1;
  assign dbg_inc = (dbg_cnt_q == '1) ? dbg_cnt_q : dbg_cnt_q + 1'b1;

  assign arm_w = CmpBits'(arm_inc);
  assign hit_w = CmpBits'(hit_inc);
  assign dbg_w = CmpBits'(dbg_inc);

  // a rise over a reference: sample > reference + limit, no wrap in SumBits
  assign smp_w   = SumBits'(in_q.sample);
  assign arm_lim = SumBits'(baseline_q) + SumBits'(cfg.tap_spike);
  assign dbg_lim = SumBits'(prev_q) + SumBits'(cfg.debug_spike);

  assign in_grace  = arm_w < CmpBits'(cfg.grace_ms);
  assign armed_tap = ((smp_w > SumBits'(cfg.tap_threshold)) || (smp_w > arm_lim)) &&
                     (hit_w > CmpBits'(cfg.debounce_ticks));
  assign debug_tap = ((smp_w > SumBits'(cfg.debug_threshold)) || (smp_w > dbg_lim)) &&
                     (dbg_w > CmpBits'(cfg.debounce_ticks));

  always_comb begin
    mode_d     = mode_q;
    arm_cnt_d  = arm_cnt_q;
    hit_cnt_d  = hit_cnt_q;
    chg_cnt_d  = chg_cnt_q;
    dbg_cnt_d  = dbg_cnt_q;
    baseline_d = baseline_q;
    prev_d     = prev_q;
    timeout_d  = timeout_q;
    hits_d     = hits_q;
    misses_d   = misses_q;
    ev         = EV_NONE;
    tm_w       = '0;

    case (in_q.operation)
      OP_TICK: begin
        arm_cnt_d = arm_inc;
        hit_cnt_d = hit_inc;
        chg_cnt_d = chg_inc;
        dbg_cnt_d = dbg_inc;

        if (mode_q == MODE_ARMED) begin
          if (!in_grace) begin
            if (armed_tap) begin
              hit_cnt_d = '0;
              ev        = EV_HIT;
              tm_w      = arm_w;
              hits_d    = (hits_q == '1) ? hits_q : hits_q + 1'b1;
              mode_d    = MODE_HIT;
              chg_cnt_d = '0;
            end else begin
              baseline_d = in_q.sample;
            end
          end
        end else if (cfg.debug_enable && debug_tap) begin
          dbg_cnt_d = '0;
          ev        = EV_DEBUG;
        end

        // timeout check sees the mode after tap detection
        if (mode_d == MODE_ARMED && arm_w > CmpBits'(timeout_q)) begin
          ev        = EV_MISS;
          tm_w      = CmpBits'(timeout_q);
          misses_d  = (misses_q == '1) ? misses_q : misses_q + 1'b1;
          mode_d    = MODE_MISS;
          chg_cnt_d = '0;
        end

        if ((mode_d == MODE_HIT || mode_d == MODE_MISS) &&
            CmpBits'(chg_cnt_d) > CmpBits'(RETURN_DELAY)) begin
          mode_d = MODE_WAIT;
        end

        prev_d = in_q.sample;
      end
      OP_START: begin
        mode_d   = MODE_WAIT;
        hits_d   = '0;
        misses_d = '0;
      end
      OP_STOP: begin
        mode_d = MODE_IDLE;
      end
      OP_ACTIVATE: begin
        if (mode_q == MODE_WAIT) begin
          mode_d     = MODE_ARMED;
          arm_cnt_d  = '0;
          timeout_d  = (in_q.timeout_ms != '0) ? in_q.timeout_ms : cfg.default_timeout_ms;
          baseline_d = in_q.sample;
        end
      end
      OP_DEACTIVATE: begin
        if (mode_q == MODE_ARMED) begin
          mode_d = MODE_WAIT;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    out_d.event_res  = ev;
    out_d.time_ms    = (tm_w > CmpBits'({TIME_BITS{1'b1}})) ? '1 : tm_w[TIME_BITS-1:0];
    out_d.mode       = mode_code(mode_d);
    out_d.hit_count  = hits_d;
    out_d.miss_count = misses_d;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // result register and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      arm_cnt_q   <= '0;
      hit_cnt_q   <= '1;
      chg_cnt_q   <= '0;
      dbg_cnt_q   <= '1;
      baseline_q  <= '0;
      prev_q      <= '0;
      timeout_q   <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        arm_cnt_q   <= arm_cnt_d;
        hit_cnt_q   <= hit_cnt_d;
        chg_cnt_q   <= chg_cnt_d;
        dbg_cnt_q   <= dbg_cnt_d;
        baseline_q  <= baseline_d;
        prev_q      <= prev_d;
        timeout_q   <= timeout_d;
        hits_q      <= hits_d;
        misses_q    <= misses_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("mode register not one-hot");

  a_hit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == EV_HIT) |-> out_q.mode == MODE_CODE_HIT)
    else $error("hit reported outside hit mode");

  a_miss_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == EV_MISS) |-> out_q.mode == MODE_CODE_MISS)
    else $error("miss reported outside miss mode");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(hits_q) && $stable(misses_q))
    else $error("state changed without an item");

endmodule
`default_nettype wire
